@@ rtl/ssc_pkg.sv @@
package ssc_pkg;

   // action codes carried in req_tuser
   localparam logic [1:0] ACT_PLOT  = 2'd0;
   localparam logic [1:0] ACT_BEGIN = 2'd1;
   localparam logic [1:0] ACT_DRAIN = 2'd2;
   localparam logic [1:0] ACT_END   = 2'd3;

   // rows_in_use register
   localparam int         CFG_BITS   = 10;
   localparam logic [9:0] ROWS_RESET = 10'd480;

   localparam int COLOR_BITS = 8;

   // controller to datapath commands
   typedef struct packed {
      logic sweep_start;  // restart the row clearing pass
      logic sweep_step;   // clear one row entry
      logic item_load;    // latch the accepted item
      logic emit_pixel;   // load a pixel result from the input item
      logic mem_read;     // read the latched item's row entry
      logic mem_merge;    // widen the row span and write it back
      logic drain_emit;   // load a span result and invalidate the row
   } ssc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [1:0] in_action;    // action of the item on the input port
      logic       in_row_ok;    // its row lies inside the table
      logic       out_busy;     // result register full and not taken
      logic       sweep_last;   // clearing pass at its last row
      logic       item_drain;   // latched item is a drain
      logic       entry_valid;  // row entry read back holds a span
   } ssc_status_type;

endpackage

@@ rtl/scanline_span_capture_core.sv @@
// Per-row span table for filled-shape drawing. A plot in direct mode gives
// one pixel result in the accept cycle's next edge; a plot in capture mode
// widens the stored min/max x of its row, and a drain of a row that holds a
// span returns that span and empties the row. One item is worked at a time:
// direct plots, end capture and items aimed at rows outside the table are
// done in the accept step; capture plots and drains of a row in the table
// go through accept, table read, and merge or drain, because the row table has one port
// with registered read data. While a result waits with rsp_tready low,
// req_tready stays low, and a drain that finds a span holds until the
// result register is free. Begin capture, and reset, run a clearing pass
// over all MAX_ROWS rows of the table (one row per cycle), during which
// req_tready stays low.
// csr_data may be written at any time and is always ready.
module scanline_span_capture_core #(
   parameter int MAX_ROWS   = 512,
   parameter int COORD_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   // input items
   input  logic                                                   req_tvalid,
   output logic                                                   req_tready,
   // x_coord, y_coord, color
   input  logic [((2*COORD_BITS+ssc_pkg::COLOR_BITS+7)/8)*8-1:0]  req_tdata,
   // action, swap_xy
   input  logic [2:0]                                             req_tuser,
   // results
   output logic                                                   rsp_tvalid,
   input  logic                                                   rsp_tready,
   // out_row, x_start, x_end, out_color
   output logic [((3*COORD_BITS+ssc_pkg::COLOR_BITS+7)/8)*8-1:0]  rsp_tdata,
   // kind
   output logic [0:0]                                             rsp_tuser,
   // rows_in_use write
   input  logic                                                   csr_valid,
   output logic                                                   csr_ready,
   input  logic [ssc_pkg::CFG_BITS-1:0]                           csr_data
);
   import ssc_pkg::*;

   ssc_cmd_type    cmd;
   ssc_status_type status;

   // sequencing of each item
   ssc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // row table, item and result registers
   ssc_dpath #(
      .MAX_ROWS   (MAX_ROWS),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

@@ rtl/ssc_ctrl.sv @@
module ssc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ssc_pkg::ssc_status_type status,
   output ssc_pkg::ssc_cmd_type    cmd
);
   import ssc_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_MERGE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       capture_ff, capture_in;
   logic       accept;

   // items are taken only in idle with room for a result
   assign req_tready = (state_ff == ST_IDLE) && !status.out_busy;
   assign accept     = req_tvalid && req_tready;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      capture_in = capture_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.item_load = 1'b1;
               unique case (status.in_action)
                  ACT_PLOT: begin
                     if (!capture_ff) begin
                        cmd.emit_pixel = 1'b1;
                     end else if (status.in_row_ok) begin
                        state_in = ST_READ;
                     end
                  end
                  ACT_BEGIN: begin
                     capture_in      = 1'b1;
                     cmd.sweep_start = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  ACT_DRAIN: begin
                     if (status.in_row_ok) begin
                        state_in = ST_READ;
                     end
                  end
                  ACT_END: begin
                     capture_in = 1'b0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_MERGE;
         end
         ST_MERGE: begin
            if (!status.item_drain) begin
               cmd.mem_merge = 1'b1;
               state_in      = ST_IDLE;
            end else if (!status.entry_valid) begin
               state_in = ST_IDLE;
            end else if (!status.out_busy) begin
               cmd.drain_emit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         capture_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         capture_ff <= capture_in;
      end
   end

   // a row read is always followed by its merge step
   a_read_then_merge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_MERGE))
      else $error("row read not followed by merge");

   // begin capture always enters the clearing pass in capture mode
   a_begin_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_start |=> (state_ff == ST_CLEAR) && capture_ff)
      else $error("begin capture did not start clearing");

   // no transfer is taken while the table is being cleared
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !cmd.item_load)
      else $error("item taken during clearing pass");

endmodule

@@ rtl/ssc_dpath.sv @@
module ssc_dpath #(
   parameter int MAX_ROWS   = 512,
   parameter int COORD_BITS = 10
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic [((2*COORD_BITS+ssc_pkg::COLOR_BITS+7)/8)*8-1:0]  req_tdata,
   input  logic [2:0]                                             req_tuser,
   output logic                                                   rsp_tvalid,
   input  logic                                                   rsp_tready,
   output logic [((3*COORD_BITS+ssc_pkg::COLOR_BITS+7)/8)*8-1:0]  rsp_tdata,
   output logic [0:0]                                             rsp_tuser,
   input  logic                                                   csr_valid,
   output logic                                                   csr_ready,
   input  logic [ssc_pkg::CFG_BITS-1:0]                           csr_data,
   input  ssc_pkg::ssc_cmd_type                                   cmd,
   output ssc_pkg::ssc_status_type                                status
);
   import ssc_pkg::*;

   localparam int ROW_BITS      = $clog2(MAX_ROWS);
   localparam int ENTRY_BITS    = 2*COORD_BITS + 1;
   localparam int RSP_DATA_BITS = ((3*COORD_BITS+COLOR_BITS+7)/8)*8;

   // input item fields
   logic [COORD_BITS-1:0] req_x, req_y, px, py, row_sel;
   logic [COLOR_BITS-1:0] req_color;
   logic [1:0]            req_action;
   logic                  req_swap;

   assign req_x      = req_tdata[COORD_BITS-1:0];
   assign req_y      = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign req_color  = req_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS];
   assign req_action = req_tuser[1:0];
   assign req_swap   = req_tuser[2];
   assign px         = req_swap ? req_y : req_x;
   assign py         = req_swap ? req_x : req_y;
   assign row_sel    = (req_action == ACT_DRAIN) ? req_y : py;

   // rows_in_use register
   logic [CFG_BITS-1:0] rows_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
      end else if (csr_valid && csr_ready) begin
         rows_ff <= csr_data;
      end
   end

   // row range check against the register and the table depth
   logic row_ok;
   assign row_ok = (32'(row_sel) < 32'(rows_ff)) && (32'(row_sel) < 32'(MAX_ROWS));

   // latched item
   logic [COORD_BITS-1:0] item_px_ff, item_row_ff;
   logic [COLOR_BITS-1:0] item_color_ff;
   logic                  item_drain_ff;

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         item_px_ff    <= px;
         item_row_ff   <= row_sel;
         item_color_ff <= req_color;
         item_drain_ff <= (req_action == ACT_DRAIN);
      end
   end

   // clearing pass counter
   logic [ROW_BITS-1:0] sweep_ff;
   logic                sweep_last;
   assign sweep_last = (sweep_ff == ROW_BITS'(MAX_ROWS - 1));

   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_start) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_step && !sweep_last) begin
         sweep_ff <= sweep_ff + ROW_BITS'(1);
      end
   end

   // row table: valid bit, min x, max x
   logic [ENTRY_BITS-1:0] mem [MAX_ROWS];
   logic [ENTRY_BITS-1:0] rd_ff, mem_wdata;
   logic [ROW_BITS-1:0]   mem_addr;
   logic                  mem_we;
   logic [COORD_BITS-1:0] rd_min, rd_max, new_min, new_max;
   logic                  rd_valid;

   assign rd_valid = rd_ff[2*COORD_BITS];
   assign rd_min   = rd_ff[2*COORD_BITS-1:COORD_BITS];
   assign rd_max   = rd_ff[COORD_BITS-1:0];
   assign new_min  = (!rd_valid || (item_px_ff < rd_min)) ? item_px_ff : rd_min;
   assign new_max  = (!rd_valid || (item_px_ff > rd_max)) ? item_px_ff : rd_max;

   assign mem_addr = cmd.sweep_step ? sweep_ff : ROW_BITS'(item_row_ff);
   assign mem_we   = cmd.sweep_step || cmd.mem_merge || cmd.drain_emit;

   always_comb begin
      if (cmd.sweep_step) begin
         mem_wdata = '0;
      end else if (cmd.mem_merge) begin
         mem_wdata = {1'b1, new_min, new_max};
      end else begin
         mem_wdata = {1'b0, rd_min, rd_max};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[mem_addr];
      end
   end

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_kind_ff;
   logic [COORD_BITS-1:0] out_row_ff, out_xs_ff, out_xe_ff;
   logic [COLOR_BITS-1:0] out_color_ff;
   logic                  load_out;

   assign load_out     = cmd.emit_pixel || cmd.drain_emit;
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pixel) begin
         out_kind_ff  <= 1'b0;
         out_row_ff   <= py;
         out_xs_ff    <= px;
         out_xe_ff    <= px;
         out_color_ff <= req_color;
      end else if (cmd.drain_emit) begin
         out_kind_ff  <= 1'b1;
         out_row_ff   <= item_row_ff;
         out_xs_ff    <= rd_min;
         out_xe_ff    <= rd_max;
         out_color_ff <= item_color_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({out_color_ff, out_xe_ff, out_xs_ff, out_row_ff});

   // status to the controller
   assign status.in_action   = req_action;
   assign status.in_row_ok   = row_ok;
   assign status.out_busy    = rsp_valid_ff && !rsp_tready;
   assign status.sweep_last  = sweep_last;
   assign status.item_drain  = item_drain_ff;
   assign status.entry_valid = rd_valid;

   // a merge works on data read in the cycle before
   a_merge_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_merge |-> $past(cmd.mem_read))
      else $error("row update without a preceding read");

   // a result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten");

   // a drain emit always presents a span result
   a_drain_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.drain_emit |=> rsp_tvalid && rsp_tuser[0])
      else $error("span result not presented");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import ssc_pkg::*;

   localparam int MAX_ROWS     = 512;
   localparam int COORD_BITS   = 10;
   localparam int REQ_W        = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;
   localparam int RSP_W        = ((3*COORD_BITS+COLOR_BITS+7)/8)*8;
   // begin capture clears one row per cycle, so idle means that long plus margin
   localparam int SETTLE       = MAX_ROWS + 16;
   localparam int RANDOM_ITEMS = 1850;
   localparam int LONG_HOLD    = 300;

   typedef struct packed {
      logic [1:0] action;
      logic [9:0] x;
      logic [9:0] y;
      logic       swap;
      logic [7:0] color;
   } plot_item_type;

   typedef struct packed {
      logic       kind;
      logic [9:0] row;
      logic [9:0] x_start;
      logic [9:0] x_end;
      logic [7:0] color;
   } span_out_type;

   typedef struct {
      plot_item_type item;
      bit            typed;
      bit            has_out;
      span_out_type  out;
   } script_step_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;   // x_coord, y_coord, color
   logic [2:0]          req_tuser;   // action, swap_xy
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;   // out_row, x_start, x_end, out_color
   logic [0:0]          rsp_tuser;   // kind
   logic                csr_valid;
   logic                csr_ready;
   logic [CFG_BITS-1:0] csr_data;

   // span table shadow
   logic [9:0]          span_lo [MAX_ROWS];
   logic [9:0]          span_hi [MAX_ROWS];
   logic [MAX_ROWS-1:0] span_live;
   bit                  capturing;
   logic [9:0]          rows_limit;

   span_out_type pending_q[$];
   int           fail_count;
   int           sent_items;
   bit           calm;
   bit           hold_request;

   scanline_span_capture_core #(
      .MAX_ROWS  (MAX_ROWS),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_500_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic bit row_in_table(input logic [9:0] row);
      return (int'(row) < int'(rows_limit)) && (int'(row) < MAX_ROWS);
   endfunction

   // 0: item ignored, 1: state changed only, 2: one result
   function automatic int span_table_step(input plot_item_type it, output span_out_type res);
      logic [9:0] px;
      logic [9:0] py;
      int         verdict;
      px      = it.swap ? it.y : it.x;
      py      = it.swap ? it.x : it.y;
      res     = '0;
      verdict = 0;
      case (it.action)
         ACT_PLOT: begin
            if (!capturing) begin
               res     = '{1'b0, py, px, px, it.color};
               verdict = 2;
            end else if (row_in_table(py)) begin
               if (!span_live[py]) begin
                  span_lo[py]   = px;
                  span_hi[py]   = px;
                  span_live[py] = 1'b1;
               end else begin
                  if (px < span_lo[py]) span_lo[py] = px;
                  if (px > span_hi[py]) span_hi[py] = px;
               end
               verdict = 1;
            end
         end
         ACT_BEGIN: begin
            span_live = '0;
            capturing = 1'b1;
            verdict   = 1;
         end
         ACT_DRAIN: begin
            if (row_in_table(it.y) && span_live[it.y]) begin
               res             = '{1'b1, it.y, span_lo[it.y], span_hi[it.y], it.color};
               span_live[it.y] = 1'b0;
               verdict         = 2;
            end
         end
         default: begin
            if (capturing) verdict = 1;
            capturing = 1'b0;
         end
      endcase
      return verdict;
   endfunction

   function automatic string show(input span_out_type o);
      return $sformatf("kind %0d row %0d x %0d..%0d color %0d",
                       o.kind, o.row, o.x_start, o.x_end, o.color);
   endfunction

   task automatic report_fail(input string what);
      if (fail_count < 10) $display("%0t: %s", $time, what);
      fail_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      span_out_type got;
      span_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser[0], rsp_tdata[9:0], rsp_tdata[19:10], rsp_tdata[29:20],
                 rsp_tdata[37:30]};
         if (pending_q.size() == 0) begin
            report_fail({"unexpected result: ", show(got)});
         end else begin
            want = pending_q.pop_front();
            if (got.kind !== want.kind || got.row !== want.row ||
                got.x_start !== want.x_start || got.x_end !== want.x_end ||
                got.color !== want.color)
               report_fail({"mismatch: expected ", show(want), ", got ", show(got)});
         end
      end
   end

   // result side: short random stalls, one long hold on request
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one transfer on the input side; entered and left at a falling edge
   task automatic send_item(input plot_item_type it, input bit typed = 1'b0,
                            input bit typed_has = 1'b0, input span_out_type typed_out = '0);
      span_out_type res;
      int           verdict;
      int           gap;
      gap = 0;
      if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-28){1'b0}}, it.color, it.y, it.x};
      req_tuser  <= {it.swap, it.action};
      do @(posedge clock); while (!req_tready);
      verdict = span_table_step(it, res);
      if (typed) begin
         if (typed_has) pending_q.push_back(typed_out);
      end else if (verdict == 2) begin
         pending_q.push_back(res);
      end
      sent_items++;
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_q.size() != 0);
   endtask

   task automatic write_rows(input logic [9:0] value);
      wait_results_drained();
      repeat (SETTLE) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      rows_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic plot_item_type rand_item(input logic [1:0] action);
      plot_item_type it;
      it.action = action;
      it.x      = 10'($urandom);
      it.y      = 10'($urandom);
      it.swap   = ($urandom_range(0, 4) == 0);
      it.color  = 8'($urandom);
      return it;
   endfunction

   // mostly rows inside the table, with its boundary and the odd far row
   function automatic logic [9:0] pick_row();
      int eff;
      eff = (int'(rows_limit) > MAX_ROWS) ? MAX_ROWS : int'(rows_limit);
      case ($urandom_range(0, 9))
         0:       return 10'($urandom_range(0, 1023));
         1:       return 10'(eff);
         2:       return (eff > 0) ? 10'(eff - 1) : 10'd0;
         default: return (eff > 0) ? 10'($urandom_range(0, eff - 1))
                                   : 10'($urandom_range(0, 1023));
      endcase
   endfunction

   // begin, plots over a few rows, drains of those rows and at times of one more, usually end
   task automatic capture_burst();
      logic [9:0]    rows [4];
      logic [9:0]    row;
      logic [9:0]    col;
      int            nrows;
      plot_item_type it;
      nrows = $urandom_range(1, 4);
      for (int i = 0; i < nrows; i++) rows[i] = pick_row();
      send_item(rand_item(ACT_BEGIN));
      repeat ($urandom_range(2, 24)) begin
         row = rows[$urandom_range(0, nrows - 1)];
         col = 10'($urandom);
         it  = rand_item(ACT_PLOT);
         if (it.swap) begin
            it.x = row;
            it.y = col;
         end else begin
            it.x = col;
            it.y = row;
         end
         send_item(it);
      end
      for (int i = 0; i < nrows; i++) begin
         it   = rand_item(ACT_DRAIN);
         it.y = rows[i];
         send_item(it);
         if ($urandom_range(0, 3) == 0) send_item(it);
      end
      if ($urandom_range(0, 2) == 0) begin
         it   = rand_item(ACT_DRAIN);
         it.y = pick_row();
         send_item(it);
      end
      if ($urandom_range(0, 3) != 0) send_item(rand_item(ACT_END));
   endtask

   task automatic direct_burst(input int count);
      if ($urandom_range(0, 1) == 0) send_item(rand_item(ACT_END));
      repeat (count) send_item(rand_item(ACT_PLOT));
   endtask

   task automatic noise_burst(input int count);
      logic [1:0] action;
      repeat (count) begin
         if ($urandom_range(0, 15) == 0) begin
            action = ACT_BEGIN;
         end else begin
            case ($urandom_range(0, 2))
               0:       action = ACT_PLOT;
               1:       action = ACT_DRAIN;
               default: action = ACT_END;
            endcase
         end
         send_item(rand_item(action));
      end
   endtask

   function automatic script_step_type entry(input logic [1:0] action, input int x, input int y,
                                             input bit swap, input logic [7:0] color,
                                             input bit typed, input bit has_out,
                                             input bit kind, input int row, input int xs,
                                             input int xe, input logic [7:0] out_color);
      script_step_type s;
      s.item    = '{action, 10'(x), 10'(y), swap, color};
      s.typed   = typed;
      s.has_out = has_out;
      s.out     = '{kind, 10'(row), 10'(xs), 10'(xe), out_color};
      return s;
   endfunction

   initial begin
      script_step_type steps[$];
      logic [9:0]      rows_plan [8];
      logic [9:0]      value;
      int              phase_end;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      rows_limit   = ROWS_RESET;
      capturing    = 1'b0;
      span_live    = '0;
      fail_count   = 0;
      sent_items   = 0;
      calm         = 1'b0;
      hold_request = 1'b0;

      // direct mode after reset, then one capture session
      steps.push_back(entry(ACT_PLOT,     0,    0, 0, 8'h00, 1, 1, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_PLOT,  1023, 1023, 0, 8'hFF, 1, 1, 0, 1023, 1023, 1023, 8'hFF));
      steps.push_back(entry(ACT_PLOT,     5,  700, 1, 8'hA5, 1, 1, 0,    5,  700,  700, 8'hA5));
      steps.push_back(entry(ACT_END,      0,    0, 0, 8'h00, 1, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_DRAIN,    0,    3, 0, 8'h11, 1, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_BEGIN,    0,    0, 0, 8'h00, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_PLOT,   100,   10, 0, 8'h01, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_PLOT,    50,   10, 0, 8'h02, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_PLOT,   900,   10, 0, 8'h03, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_PLOT,    10,  300, 1, 8'h04, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_PLOT,  1023,  479, 0, 8'h05, 0, 0, 0,    0,    0,    0, 8'h00));
      // rows past the table are dropped
      steps.push_back(entry(ACT_PLOT,     7,  480, 0, 8'h06, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_PLOT,     7, 1023, 0, 8'h07, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_PLOT,   480,    3, 1, 8'h08, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_DRAIN,    0,   10, 0, 8'h3C, 1, 1, 1,   10,   50,  900, 8'h3C));
      steps.push_back(entry(ACT_DRAIN,    0,   10, 0, 8'h3C, 1, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_DRAIN,    0,  480, 0, 8'h3C, 1, 0, 0,    0,    0,    0, 8'h00));
      // spans survive end capture
      steps.push_back(entry(ACT_END,      0,    0, 0, 8'h00, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_DRAIN,    0,  479, 0, 8'hFF, 1, 1, 1,  479, 1023, 1023, 8'hFF));
      steps.push_back(entry(ACT_PLOT,    12,   34, 0, 8'h5A, 0, 0, 0,    0,    0,    0, 8'h00));
      // a second begin clears the table again
      steps.push_back(entry(ACT_BEGIN,    0,    0, 0, 8'h00, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_PLOT,     0,    0, 0, 8'h00, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_BEGIN,    0,    0, 0, 8'h00, 0, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_DRAIN,    0,    0, 0, 8'h00, 1, 0, 0,    0,    0,    0, 8'h00));
      steps.push_back(entry(ACT_END,      0,    0, 0, 8'h00, 0, 0, 0,    0,    0,    0, 8'h00));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (steps[i]) send_item(steps[i].item, steps[i].typed, steps[i].has_out, steps[i].out);

      // random phases, one table height each, extremes first
      rows_plan = '{10'd1, 10'd1023, 10'd0, 10'd512, 10'd511, 10'd513, 10'd0, 10'd480};
      for (int p = 0; p < 8; p++) begin
         value = (p == 6) ? 10'($urandom_range(2, 1023)) : rows_plan[p];
         write_rows(value);
         if (p == 7) calm = 1'b1;
         phase_end = (RANDOM_ITEMS * (p + 1)) / 8;
         if (p == 3) begin
            // long result hold while plots keep coming, then let everything drain
            hold_request = 1'b1;
            send_item(rand_item(ACT_END));
            repeat (40) send_item(rand_item(ACT_PLOT));
            wait_results_drained();
         end
         while (sent_items < phase_end) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: capture_burst();
               5, 6, 7:       direct_burst($urandom_range(1, 12));
               default:       noise_burst($urandom_range(1, 8));
            endcase
         end
      end

      req_tvalid <= 1'b0;
      for (int n = 0; n < 20000 && pending_q.size() != 0; n++) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (pending_q.size() != 0)
         report_fail($sformatf("%0d expected results never arrived", pending_q.size()));
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
